>>> src/assert_macros.svh
// Assertion helpers used by the checker file cclist_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property, checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/cclist_pkg.sv
package cclist_pkg;

  localparam int unsigned CAPACITY = 16;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned KEY_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned FILL_W   = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    logic    capture;
    logic    idx_clr;
    logic    idx_inc;
    logic    pos_load;
    logic    rd_en;
    logic    rd_next;
    logic    wr_en;
    logic    wr_at_cnt;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
    logic    res_hit;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic op_insert;
    logic op_remove;
    logic op_search;
    logic full;
    logic empty;
    logic match;
    logic last;
  } sts_t;

endpackage

>>> src/cclist_if.sv
interface cclist_in_if;
  logic                              valid;
  logic                              ready;
  logic [cclist_pkg::MODE_W-1:0]     mode;
  logic [cclist_pkg::KEY_W-1:0]      key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

interface cclist_out_if;
  logic                              valid;
  logic                              ready;
  logic [cclist_pkg::STATUS_W-1:0]   status;
  logic [cclist_pkg::IDX_W-1:0]      found_index;
  logic [cclist_pkg::FILL_W-1:0]     fill_count;

  modport source (output valid, output status, output found_index, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input found_index, input fill_count,
                  output ready);
endinterface

>>> src/cclist_ctrl.sv
module cclist_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  cclist_pkg::sts_t sts_i,
  output cclist_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_CMP  = 7'b0001000,
    S_SRD  = 7'b0010000,
    S_SWR  = 7'b0100000,
    S_RES  = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  cclist_pkg::status_e st_q, st_d;
  logic                hit_q, hit_d;
  logic                out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        hit_d         = 1'b0;
        cmd_o.idx_clr = 1'b1;
        priority if (sts_i.op_insert) begin
          if (sts_i.full) begin
            st_d = cclist_pkg::ST_FULL;
          end else begin
            cmd_o.wr_en     = 1'b1;
            cmd_o.wr_at_cnt = 1'b1;
            cmd_o.cnt_inc   = 1'b1;
            st_d            = cclist_pkg::ST_OK;
          end
          state_d = S_RES;
        end else if (sts_i.op_remove || sts_i.op_search) begin
          if (sts_i.empty) begin
            st_d    = cclist_pkg::ST_EMPTY;
            state_d = S_RES;
          end else begin
            state_d = S_RD;
          end
        end else begin
          st_d    = cclist_pkg::ST_OK;
          state_d = S_RES;
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        priority if (sts_i.match) begin
          hit_d          = 1'b1;
          st_d           = cclist_pkg::ST_OK;
          cmd_o.pos_load = 1'b1;
          state_d        = sts_i.op_remove ? S_SRD : S_RES;
        end else if (sts_i.last) begin
          st_d    = cclist_pkg::ST_MISSING;
          state_d = S_RES;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      S_SRD: begin
        if (sts_i.last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_RES;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = S_SWR;
        end
      end
      S_SWR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_SRD;
      end
      S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = st_q;
          cmd_o.res_hit    = hit_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= cclist_pkg::ST_OK;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/cclist_dp.sv
module cclist_dp #(
  parameter int unsigned CAPACITY = cclist_pkg::CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cclist_pkg::MODE_W-1:0]     in_mode_i,
  input  logic [cclist_pkg::KEY_W-1:0]      in_key_i,
  input  cclist_pkg::cmd_t                  cmd_i,
  output cclist_pkg::sts_t                  sts_o,
  output logic [cclist_pkg::STATUS_W-1:0]   status_o,
  output logic [cclist_pkg::IDX_W-1:0]      found_index_o,
  output logic [cclist_pkg::FILL_W-1:0]     fill_count_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [cclist_pkg::KEY_W-1:0] mem_q [CAPACITY];

  logic [cclist_pkg::MODE_W-1:0]   mode_q;
  logic [cclist_pkg::KEY_W-1:0]    key_q;
  logic [cclist_pkg::KEY_W-1:0]    rdata_q;
  logic [CW-1:0]                   idx_q;
  logic [CW-1:0]                   cnt_q;
  logic [IW-1:0]                   pos_q;
  logic [cclist_pkg::STATUS_W-1:0] status_q;
  logic [cclist_pkg::IDX_W-1:0]    found_q;
  logic [cclist_pkg::FILL_W-1:0]   fill_q;

  logic [CW-1:0]                   idx_nx;
  logic [IW-1:0]                   rd_addr;
  logic [IW-1:0]                   wr_addr;
  logic [cclist_pkg::KEY_W-1:0]    wdata;
  logic [IW+cclist_pkg::IDX_W-1:0] found_ext;
  logic [CW+cclist_pkg::FILL_W-1:0] fill_ext;

  assign idx_nx    = idx_q + CW'(1);
  assign rd_addr   = cmd_i.rd_next ? idx_nx[IW-1:0] : idx_q[IW-1:0];
  assign wr_addr   = cmd_i.wr_at_cnt ? cnt_q[IW-1:0] : idx_q[IW-1:0];
  assign wdata     = cmd_i.wr_at_cnt ? key_q : rdata_q;
  assign found_ext = {{cclist_pkg::IDX_W{1'b0}}, pos_q};
  assign fill_ext  = {{cclist_pkg::FILL_W{1'b0}}, cnt_q};

  assign sts_o.op_insert = (mode_q == cclist_pkg::MODE_INSERT);
  assign sts_o.op_remove = (mode_q == cclist_pkg::MODE_REMOVE);
  assign sts_o.op_search = (mode_q == cclist_pkg::MODE_SEARCH);
  assign sts_o.full      = (cnt_q == CW'(CAPACITY));
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.match     = (rdata_q == key_q);
  assign sts_o.last      = (idx_nx == cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= in_mode_i;
      key_q  <= in_key_i;
    end
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_nx;
    end
    if (cmd_i.pos_load) begin
      pos_q <= idx_q[IW-1:0];
    end
    if (cmd_i.res_load) begin
      status_q <= cmd_i.res_status;
      found_q  <= cmd_i.res_hit ? found_ext[cclist_pkg::IDX_W-1:0] : '0;
      fill_q   <= fill_ext[cclist_pkg::FILL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign fill_count_o  = fill_q;

endmodule

>>> src/compacting_char_list_engine.sv
// Insert, unused modes, and a search or remove on an empty list go from decode to the result;
// otherwise search and remove scan entry by entry, and a remove hit shifts later entries down.
// One item at a time; the next beat is taken the cycle after the result is registered.
// Reset (asynchronous, active low) clears the fill count and the controller;
// list contents stay undefined and need no clearing pass.
module compacting_char_list_engine #(
  parameter int unsigned CAPACITY = cclist_pkg::CAPACITY
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cclist_in_if.sink    in_i,
  cclist_out_if.source out_o
);

  cclist_pkg::cmd_t cmd;
  cclist_pkg::sts_t sts;

  cclist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cclist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mode_i     (in_i.mode),
    .in_key_i      (in_i.key),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (out_o.status),
    .found_index_o (out_o.found_index),
    .fill_count_o  (out_o.fill_count)
  );

endmodule

>>> src/cclist_chk.sv
`include "assert_macros.svh"

module cclist_chk #(
  parameter int unsigned CAPACITY = cclist_pkg::CAPACITY
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [cclist_pkg::STATUS_W-1:0]   out_status_i,
  input logic [cclist_pkg::FILL_W-1:0]     out_fill_count_i
);

  `ASSERT_RST(a_out_hold, clk_i, rst_ni,
    out_valid_i && !out_ready_i |=> out_valid_i,
    "result dropped while stalled")
  `ASSERT_RST(a_busy_after_accept, clk_i, rst_ni,
    in_valid_i && in_ready_i |=> !in_ready_i,
    "second beat taken while busy")
  `ASSERT_RST(a_empty_count, clk_i, rst_ni,
    out_valid_i && out_status_i == cclist_pkg::ST_EMPTY |-> out_fill_count_i == '0,
    "empty status with nonzero count")
  `ASSERT_RST(a_fill_bound, clk_i, rst_ni,
    out_valid_i |-> 32'(out_fill_count_i) <= CAPACITY,
    "fill count above capacity")
  `ASSERT_ALWAYS(a_reset_idle, clk_i,
    !rst_ni |=> !out_valid_i,
    "result valid during reset")

endmodule

bind compacting_char_list_engine cclist_chk #(
  .CAPACITY (CAPACITY)
) u_cclist_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_status_i     (out_o.status),
  .out_fill_count_i (out_o.fill_count)
);
